@@ src/pps_pkg.sv @@
// ----------------------------------------------------------------------------
// pps_pkg - shared constants for the preemptive priority scheduler
// Table size, time width, command codes and stream field layout.
// ----------------------------------------------------------------------------
package pps_pkg;

    // table and time sizing
    localparam int SLOTS     = 16;
    localparam int TIME_BITS = 16;
    localparam int SLOT_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PAD_SLOTS = 1 << SLOT_BITS;

    // payload field widths
    localparam int ID_BITS    = 4;
    localparam int BURST_BITS = 8;
    localparam int PRIO_BITS  = 8;
    localparam int OUT_T_BITS = 16;

    // stream widths
    localparam int S_TDATA_BITS = 24;
    localparam int M_TDATA_BITS = 56;
    localparam int M_TUSER_BITS = 3;

    // command codes carried in the slave-side tuser
    typedef enum logic {
        CMD_ARRIVE = 1'b0,
        CMD_TICK   = 1'b1
    } t_cmd;

endpackage

@@ src/preemptive_priority_scheduler_unit.sv @@
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_unit - priority scheduler over a ready table
// Arrive requests fill the lowest free slot, tick requests run the best task.
// ----------------------------------------------------------------------------
// a request is held in the input register, then in the result register, and
//   leaves on the master side from the result register
// throughput: one request per cycle; a sink stall holds both registers; the
//   slot table updates as the result register loads, so the next request
//   sees the new table; the minimum search is a compare tree between the regs
// reset clears all slot valid bits, the time counter and both stage valids
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_unit
    import pps_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // slave side
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // tdata: task_id[3:0], burst_len[11:4], prio_level[19:12], zero pad
    input  logic [S_TDATA_BITS-1:0] s_axis_tdata,
    // tuser: cmd[0]
    input  logic                    s_axis_tuser,
    // master side
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // tdata: run_id[3:0], completion_time[19:4], turnaround[35:20],
    //        waiting[51:36], zero pad
    output logic [M_TDATA_BITS-1:0] m_axis_tdata,
    // tuser: idle[0], finished[1], rejected[2]
    output logic [M_TUSER_BITS-1:0] m_axis_tuser
);

    // input register
    logic                  r_in_valid;
    t_cmd                  r_in_cmd;
    logic [ID_BITS-1:0]    r_in_id;
    logic [BURST_BITS-1:0] r_in_burst;
    logic [PRIO_BITS-1:0]  r_in_prio;

    // result register
    logic                    r_out_valid;
    logic [M_TDATA_BITS-1:0] r_out_tdata;
    logic [M_TUSER_BITS-1:0] r_out_tuser;
    logic [M_TDATA_BITS-1:0] n_out_tdata;
    logic [M_TUSER_BITS-1:0] n_out_tuser;

    // slot table and time
    logic [SLOTS-1:0]     r_valid;
    logic [SLOTS-1:0]     n_valid;
    logic [ID_BITS-1:0]   r_task    [SLOTS];
    logic [BURST_BITS-1:0] r_burst  [SLOTS];
    logic [BURST_BITS-1:0] r_served [SLOTS];
    logic [PRIO_BITS-1:0] r_prio    [SLOTS];
    logic [TIME_BITS-1:0] r_arrival [SLOTS];
    logic [TIME_BITS-1:0] r_now;
    logic [TIME_BITS-1:0] n_now;

    logic advance;
    logic fire;

    // compare tree nodes
    logic                 tr_valid [SLOT_BITS+1][PAD_SLOTS];
    logic [SLOT_BITS-1:0] tr_idx   [SLOT_BITS+1][PAD_SLOTS];
    logic [PRIO_BITS-1:0] tr_prio  [SLOT_BITS+1][PAD_SLOTS];
    logic [TIME_BITS-1:0] tr_age   [SLOT_BITS+1][PAD_SLOTS];

    logic                 best_found;
    logic [SLOT_BITS-1:0] best_idx;
    logic                 free_found;
    logic [SLOT_BITS-1:0] free_idx;

    logic [BURST_BITS-1:0] sel_served_inc;
    logic [BURST_BITS-1:0] sel_burst;
    logic                  sel_done;
    logic [TIME_BITS-1:0]  ct;
    logic [TIME_BITS-1:0]  tat;
    logic [TIME_BITS-1:0]  wt;
    logic [TIME_BITS-1:0]  burst_ext;

    // stage handshakes
    assign advance       = !r_out_valid || m_axis_tready;
    assign fire          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_tdata;
    assign m_axis_tuser  = r_out_tuser;

    // input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_cmd   <= t_cmd'(s_axis_tuser);
            r_in_id    <= s_axis_tdata[3:0];
            r_in_burst <= s_axis_tdata[11:4];
            r_in_prio  <= s_axis_tdata[19:12];
        end
    end

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int k = SLOTS - 1; k >= 0; k--) begin
            if (!r_valid[k]) begin
                free_found = 1'b1;
                free_idx   = SLOT_BITS'(k);
            end
        end
    end

    // best ready slot: lower prio, then larger age, then lower index
    always_comb begin
        for (int l = 0; l <= SLOT_BITS; l++) begin
            for (int j = 0; j < PAD_SLOTS; j++) begin
                tr_valid[l][j] = 1'b0;
                tr_idx[l][j]   = '0;
                tr_prio[l][j]  = '0;
                tr_age[l][j]   = '0;
            end
        end
        for (int j = 0; j < SLOTS; j++) begin
            tr_valid[0][j] = r_valid[j];
            tr_idx[0][j]   = SLOT_BITS'(j);
            tr_prio[0][j]  = r_prio[j];
            tr_age[0][j]   = r_now - r_arrival[j];
        end
        for (int l = 0; l < SLOT_BITS; l++) begin
            for (int j = 0; j < (PAD_SLOTS >> (l + 1)); j++) begin
                if (tr_valid[l][2*j+1] && (!tr_valid[l][2*j] ||
                    (tr_prio[l][2*j+1] < tr_prio[l][2*j]) ||
                    ((tr_prio[l][2*j+1] == tr_prio[l][2*j]) &&
                     (tr_age[l][2*j+1] > tr_age[l][2*j])))) begin
                    tr_valid[l+1][j] = 1'b1;
                    tr_idx[l+1][j]   = tr_idx[l][2*j+1];
                    tr_prio[l+1][j]  = tr_prio[l][2*j+1];
                    tr_age[l+1][j]   = tr_age[l][2*j+1];
                end else begin
                    tr_valid[l+1][j] = tr_valid[l][2*j];
                    tr_idx[l+1][j]   = tr_idx[l][2*j];
                    tr_prio[l+1][j]  = tr_prio[l][2*j];
                    tr_age[l+1][j]   = tr_age[l][2*j];
                end
            end
        end
        best_found = tr_valid[SLOT_BITS][0];
        best_idx   = tr_idx[SLOT_BITS][0];
    end

    // service and completion figures for the selected slot
    always_comb begin
        sel_burst      = r_burst[best_idx];
        sel_served_inc = (r_served[best_idx] != '1) ? r_served[best_idx] + 1'b1
                                                    : r_served[best_idx];
        sel_done       = sel_served_inc >= sel_burst;
        burst_ext      = TIME_BITS'(sel_burst);
        ct             = r_now + 1'b1;
        tat            = ct - r_arrival[best_idx];
        wt             = (tat >= burst_ext) ? tat - burst_ext : '0;
    end

    // next table state and result
    always_comb begin
        n_valid     = r_valid;
        n_now       = r_now;
        n_out_tdata = '0;
        n_out_tuser = '0;
        case (r_in_cmd)
            CMD_ARRIVE: begin
                if (free_found) begin
                    n_valid[free_idx] = 1'b1;
                end else begin
                    n_out_tuser[2] = 1'b1;
                end
            end
            CMD_TICK: begin
                n_now = r_now + 1'b1;
                if (!best_found) begin
                    n_out_tuser[0] = 1'b1;
                end else begin
                    n_out_tdata[3:0] = r_task[best_idx];
                    if (sel_done) begin
                        n_valid[best_idx]  = 1'b0;
                        n_out_tuser[1]     = 1'b1;
                        n_out_tdata[19:4]  = OUT_T_BITS'(ct);
                        n_out_tdata[35:20] = OUT_T_BITS'(tat);
                        n_out_tdata[51:36] = OUT_T_BITS'(wt);
                    end
                end
            end
            default: begin
                n_valid = r_valid;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_valid     <= '0;
            r_now       <= '0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_valid <= n_valid;
                r_now   <= n_now;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_tdata <= n_out_tdata;
            r_out_tuser <= n_out_tuser;
        end
    end

    // slot payload writes
    always_ff @(posedge i_clk) begin
        if (fire) begin
            if (r_in_cmd == CMD_ARRIVE && free_found) begin
                r_task[free_idx]    <= r_in_id;
                r_burst[free_idx]   <= r_in_burst;
                r_served[free_idx]  <= '0;
                r_prio[free_idx]    <= r_in_prio;
                r_arrival[free_idx] <= r_now;
            end else if (r_in_cmd == CMD_TICK && best_found) begin
                r_served[best_idx] <= sel_served_inc;
            end
        end
    end

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb - self-checking bench for the preemptive priority scheduler
// Streams arrive and tick requests into the scheduler and checks every result
// against a cycle-free model of the ready table, under random source gaps and
// sink stalls. Covers full-table rejects, priority and age ties, zero bursts
// and duplicate task ids.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    import pps_pkg::*;

    // request and result layouts as seen on the streams
    typedef struct packed {
        t_cmd                  cmd;
        logic [ID_BITS-1:0]    task_id;
        logic [BURST_BITS-1:0] burst;
        logic [PRIO_BITS-1:0]  prio;
    } t_sched_req;

    typedef struct packed {
        logic [ID_BITS-1:0]    run_id;
        logic                  idle;
        logic                  finished;
        logic [OUT_T_BITS-1:0] ct;
        logic [OUT_T_BITS-1:0] tat;
        logic [OUT_T_BITS-1:0] wt;
        logic                  rejected;
    } t_sched_result;

    // clock, reset and stream signals
    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    // tdata: task_id[3:0], burst_len[11:4], prio_level[19:12], zero pad
    logic [S_TDATA_BITS-1:0] s_axis_tdata = '0;
    // tuser: cmd[0]
    logic                    s_axis_tuser = 1'b0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    // tdata: run_id[3:0], completion_time[19:4], turnaround[35:20],
    //        waiting[51:36], zero pad
    logic [M_TDATA_BITS-1:0] m_axis_tdata;
    // tuser: idle[0], finished[1], rejected[2]
    logic [M_TUSER_BITS-1:0] m_axis_tuser;

    // model of the ready table
    logic                  tbl_valid   [SLOTS];
    logic [ID_BITS-1:0]    tbl_task    [SLOTS];
    logic [BURST_BITS-1:0] tbl_burst   [SLOTS];
    logic [BURST_BITS-1:0] tbl_served  [SLOTS];
    logic [PRIO_BITS-1:0]  tbl_prio    [SLOTS];
    logic [TIME_BITS-1:0]  tbl_arrival [SLOTS];
    logic [TIME_BITS-1:0]  sched_now;

    // stimulus and expectation stores
    t_sched_req    pending_reqs[$];
    t_sched_result expected_results[$];
    t_sched_req    drv_req;

    int src_gap_pct    = 0;
    int sink_stall_pct = 0;
    int err_count      = 0;
    int n_sent         = 0;
    int n_arrive       = 0;
    int n_checked      = 0;
    int n_finished     = 0;
    int n_idle         = 0;
    int n_rejected     = 0;

    preemptive_priority_scheduler_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // watchdog
    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // report one error line and count it
    task automatic flag_error(input string msg);
        $display("[%0t] error: %s", $time, msg);
        err_count++;
    endtask

    // one request applied to the table model, returns the result it causes
    function automatic t_sched_result schedule_step(input t_sched_req r);
        t_sched_result        res;
        int                   k;
        int                   free_idx;
        int                   best;
        logic [TIME_BITS-1:0] age;
        logic [TIME_BITS-1:0] best_age;
        logic [TIME_BITS-1:0] ct;
        logic [TIME_BITS-1:0] tat;
        logic [TIME_BITS-1:0] wt;
        logic [TIME_BITS-1:0] burst_ext;
        res      = '0;
        free_idx = -1;
        best     = -1;
        best_age = '0;
        if (r.cmd == CMD_ARRIVE) begin
            // lowest free slot takes the task
            for (k = 0; k < SLOTS; k++)
                if (!tbl_valid[k] && free_idx < 0)
                    free_idx = k;
            if (free_idx < 0) begin
                res.rejected = 1'b1;
            end else begin
                tbl_valid[free_idx]   = 1'b1;
                tbl_task[free_idx]    = r.task_id;
                tbl_burst[free_idx]   = r.burst;
                tbl_served[free_idx]  = '0;
                tbl_prio[free_idx]    = r.prio;
                tbl_arrival[free_idx] = sched_now;
            end
            return res;
        end
        // lowest priority value, then oldest, then lowest slot
        for (k = 0; k < SLOTS; k++) begin
            if (tbl_valid[k]) begin
                age = sched_now - tbl_arrival[k];
                if (best < 0 || tbl_prio[k] < tbl_prio[best] ||
                    (tbl_prio[k] == tbl_prio[best] && age > best_age)) begin
                    best     = k;
                    best_age = age;
                end
            end
        end
        if (best < 0) begin
            res.idle = 1'b1;
        end else begin
            res.run_id = tbl_task[best];
            if (tbl_served[best] != '1)
                tbl_served[best] = tbl_served[best] + 1'b1;
            if (tbl_served[best] >= tbl_burst[best]) begin
                ct        = sched_now + 1'b1;
                tat       = ct - tbl_arrival[best];
                burst_ext = TIME_BITS'(tbl_burst[best]);
                wt        = (tat >= burst_ext) ? tat - burst_ext : '0;
                res.finished = 1'b1;
                res.ct       = ct[OUT_T_BITS-1:0];
                res.tat      = tat[OUT_T_BITS-1:0];
                res.wt       = wt[OUT_T_BITS-1:0];
                tbl_valid[best] = 1'b0;
            end
        end
        sched_now = sched_now + 1'b1;
        return res;
    endfunction

    // queue one request for the driver
    task automatic push_req(input t_cmd c, input int id, input int burst, input int prio);
        t_sched_req r;
        r.cmd     = c;
        r.task_id = id[ID_BITS-1:0];
        r.burst   = burst[BURST_BITS-1:0];
        r.prio    = prio[PRIO_BITS-1:0];
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    // random request: short bursts mostly, clustered priorities for ties
    task automatic push_random_req();
        t_cmd c;
        int   burst;
        int   prio;
        int   roll;
        c    = ($urandom_range(0, 99) < 56) ? CMD_TICK : CMD_ARRIVE;
        roll = $urandom_range(0, 99);
        if (roll < 2)
            burst = 0;
        else if (roll < 70)
            burst = $urandom_range(1, 6);
        else if (roll < 92)
            burst = $urandom_range(7, 40);
        else
            burst = $urandom_range(41, 255);
        prio = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 7) : $urandom_range(0, 255);
        push_req(c, $urandom_range(0, 15), burst, prio);
    endtask

    // hold the source until every request has been answered
    task automatic wait_all_done();
        while (pending_reqs.size() != 0 || expected_results.size() != 0 || s_axis_tvalid)
            @(posedge i_clk);
    endtask

    // reset
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // source driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results.insert(expected_results.size(), schedule_step(drv_req));
                n_sent++;
                if (drv_req.cmd == CMD_ARRIVE)
                    n_arrive++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= src_gap_pct) begin
                    drv_req = pending_reqs.pop_front();
                    s_axis_tdata  <= {{(S_TDATA_BITS-ID_BITS-BURST_BITS-PRIO_BITS){1'b0}},
                                      drv_req.prio, drv_req.burst, drv_req.task_id};
                    s_axis_tuser  <= drv_req.cmd;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_sched_result got;
        t_sched_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.run_id   = m_axis_tdata[3:0];
            got.ct       = m_axis_tdata[19:4];
            got.tat      = m_axis_tdata[35:20];
            got.wt       = m_axis_tdata[51:36];
            got.idle     = m_axis_tuser[0];
            got.finished = m_axis_tuser[1];
            got.rejected = m_axis_tuser[2];
            if (expected_results.size() == 0) begin
                flag_error("result with no request outstanding");
            end else begin
                want = expected_results.pop_front();
                if (got.run_id !== want.run_id)
                    flag_error($sformatf("result %0d run_id got %0d exp %0d",
                                         n_checked, got.run_id, want.run_id));
                if (got.idle !== want.idle)
                    flag_error($sformatf("result %0d idle got %0b exp %0b",
                                         n_checked, got.idle, want.idle));
                if (got.finished !== want.finished)
                    flag_error($sformatf("result %0d finished got %0b exp %0b",
                                         n_checked, got.finished, want.finished));
                if (got.ct !== want.ct)
                    flag_error($sformatf("result %0d completion_time got %0d exp %0d",
                                         n_checked, got.ct, want.ct));
                if (got.tat !== want.tat)
                    flag_error($sformatf("result %0d turnaround got %0d exp %0d",
                                         n_checked, got.tat, want.tat));
                if (got.wt !== want.wt)
                    flag_error($sformatf("result %0d waiting got %0d exp %0d",
                                         n_checked, got.wt, want.wt));
                if (got.rejected !== want.rejected)
                    flag_error($sformatf("result %0d rejected got %0b exp %0b",
                                         n_checked, got.rejected, want.rejected));
                n_finished += want.finished;
                n_idle     += want.idle;
                n_rejected += want.rejected;
            end
            n_checked++;
        end
        m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // stimulus sequence
    initial begin
        int k;
        for (k = 0; k < SLOTS; k++) begin
            tbl_valid[k]   = 1'b0;
            tbl_task[k]    = '0;
            tbl_burst[k]   = '0;
            tbl_served[k]  = '0;
            tbl_prio[k]    = '0;
            tbl_arrival[k] = '0;
        end
        sched_now = '0;
        @(posedge i_clk iff i_rst_n);

        // directed: idle tick, field extremes, zero burst, slot and age ties
        push_req(CMD_TICK, 0, 0, 0);
        push_req(CMD_ARRIVE, 15, 255, 255);
        push_req(CMD_ARRIVE, 0, 1, 0);
        push_req(CMD_ARRIVE, 3, 0, 0);
        push_req(CMD_TICK, 5, 17, 200);
        push_req(CMD_TICK, 10, 128, 1);
        push_req(CMD_ARRIVE, 7, 3, 10);
        push_req(CMD_TICK, 0, 0, 0);
        push_req(CMD_ARRIVE, 8, 3, 10);
        push_req(CMD_TICK, 15, 255, 255);
        // same id twice in the table
        push_req(CMD_ARRIVE, 7, 1, 200);
        // fill the remaining slots, then one arrive too many
        for (k = 0; k < SLOTS - 4; k++)
            push_req(CMD_ARRIVE, $urandom_range(0, 15), $urandom_range(1, 4),
                     $urandom_range(0, 255));
        push_req(CMD_ARRIVE, 9, 9, 9);
        wait_all_done();

        // random, mostly busy source into a mostly stalled sink
        src_gap_pct    = 19;
        sink_stall_pct = 84;
        repeat (450) push_random_req();
        wait_all_done();

        // random, slow source into a mostly ready sink
        src_gap_pct    = 84;
        sink_stall_pct = 19;
        repeat (450) push_random_req();
        wait_all_done();

        // random, back to back into an always ready sink
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        repeat (500) push_random_req();
        wait_all_done();

        repeat (10) @(posedge i_clk);
        if (expected_results.size() != 0)
            flag_error($sformatf("%0d results never arrived", expected_results.size()));

        $display("covered %0d requests (%0d arrive, %0d tick), %0d results checked",
                 n_sent, n_arrive, n_sent - n_arrive, n_checked);
        $display("%0d completions, %0d idle ticks, %0d full-table rejects",
                 n_finished, n_idle, n_rejected);
        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
